FILE: design/ipv4_range_to_cidr_unit_assert.svh
// Assertion macros for the range-to-prefix unit.
`ifndef IPV4_RANGE_TO_CIDR_UNIT_ASSERT_SVH
`define IPV4_RANGE_TO_CIDR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define IPV4C_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define IPV4C_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define IPV4C_ASSERT(label, clk, rst, expr)

`define IPV4C_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/ipv4c_pkg.sv
package ipv4c_pkg;

   localparam int unsigned FIELD_WIDTH = 32;
   localparam int unsigned PLEN_WIDTH  = 6;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic load;
      logic grow;
      logic shrink;
      logic emit;
      logic emit_err;
   } cmd_type;

   typedef struct packed {
      logic range_bad;
      logic fit_cur;
      logic fit_up;
      logic is_last;
      logic rsp_free;
   } status_type;

endpackage

FILE: design/ipv4c_ctrl.sv
module ipv4c_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ipv4c_pkg::status_type status_i,
   output ipv4c_pkg::cmd_type    cmd_o
);

   ipv4c_pkg::state_type state_ff;
   ipv4c_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipv4c_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_o     = '0;
      req_ready = 1'b0;
      case (state_ff)
         ipv4c_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.load = 1'b1;
               state_in   = ipv4c_pkg::ST_WALK;
            end
         end
         ipv4c_pkg::ST_WALK: begin
            if (status_i.range_bad) begin
               if (status_i.rsp_free) begin
                  cmd_o.emit_err = 1'b1;
                  state_in       = ipv4c_pkg::ST_IDLE;
               end
            end else if (!status_i.fit_cur) begin
               cmd_o.shrink = 1'b1;
            end else if (status_i.fit_up) begin
               cmd_o.grow = 1'b1;
            end else if (status_i.rsp_free) begin
               cmd_o.emit = 1'b1;
               if (status_i.is_last) begin
                  state_in = ipv4c_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ipv4c_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/ipv4c_datapath.sv
`include "ipv4_range_to_cidr_unit_assert.svh"

module ipv4c_datapath #(
   parameter int unsigned ADDR_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [ipv4c_pkg::FIELD_WIDTH-1:0]     req_start_addr,
   input  logic [ipv4c_pkg::FIELD_WIDTH-1:0]     req_end_addr,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ipv4c_pkg::FIELD_WIDTH-1:0]     rsp_block_base,
   output logic [ipv4c_pkg::PLEN_WIDTH-1:0]      rsp_prefix_len,
   output logic                                  rsp_last_block,
   output logic                                  rsp_range_error,
   input  ipv4c_pkg::cmd_type                    cmd_i,
   output ipv4c_pkg::status_type                 status_o
);

   localparam int unsigned KW = $clog2(ADDR_WIDTH + 1);

   logic [ADDR_WIDTH-1:0] cur_ff, cur_in;
   logic [ADDR_WIDTH-1:0] end_ff, end_in;
   logic [KW-1:0]         k_ff, k_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [ipv4c_pkg::FIELD_WIDTH-1:0]    base_ff, base_in;
   logic [ipv4c_pkg::PLEN_WIDTH-1:0]     plen_ff, plen_in;
   logic                                 last_ff, last_in;
   logic                                 err_ff, err_in;

   logic [ADDR_WIDTH-1:0] mask_cur;
   logic [ADDR_WIDTH-1:0] mask_up;
   logic [ADDR_WIDTH-1:0] blk_end;

   // mask_cur covers the low k bits; shift by ADDR_WIDTH gives all ones
   assign mask_cur = ~({ADDR_WIDTH{1'b1}} << k_ff);
   assign mask_up  = {mask_cur[ADDR_WIDTH-2:0], 1'b1};
   assign blk_end  = cur_ff | mask_cur;

   assign status_o.range_bad = cur_ff > end_ff;
   assign status_o.fit_cur   = ((cur_ff & mask_cur) == '0) && (blk_end <= end_ff);
   assign status_o.fit_up    = (k_ff < KW'(ADDR_WIDTH)) && ((cur_ff & mask_up) == '0)
                               && ((cur_ff | mask_up) <= end_ff);
   assign status_o.is_last   = blk_end == end_ff;
   assign status_o.rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cur_in       = cur_ff;
      end_in       = end_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      base_in      = base_ff;
      plen_in      = plen_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      if (cmd_i.load) begin
         cur_in = ADDR_WIDTH'(req_start_addr);
         end_in = ADDR_WIDTH'(req_end_addr);
         k_in   = '0;
      end
      if (cmd_i.grow) begin
         k_in = k_ff + KW'(1);
      end
      if (cmd_i.shrink) begin
         k_in = k_ff - KW'(1);
      end
      if (cmd_i.emit) begin
         rsp_valid_in = 1'b1;
         base_in      = ipv4c_pkg::FIELD_WIDTH'(cur_ff);
         plen_in      = ipv4c_pkg::PLEN_WIDTH'(KW'(ADDR_WIDTH) - k_ff);
         last_in      = status_o.is_last;
         err_in       = 1'b0;
         cur_in       = blk_end + ADDR_WIDTH'(1);
      end
      if (cmd_i.emit_err) begin
         rsp_valid_in = 1'b1;
         base_in      = '0;
         plen_in      = '0;
         last_in      = 1'b1;
         err_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      end_ff  <= end_in;
      base_ff <= base_in;
      plen_ff <= plen_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_block_base  = base_ff;
   assign rsp_prefix_len  = plen_ff;
   assign rsp_last_block  = last_ff;
   assign rsp_range_error = err_ff;

   `IPV4C_ASSERT(a_k_bound, clock, reset, k_ff <= KW'(ADDR_WIDTH))
   `IPV4C_ASSERT(a_cmd_onehot, clock, reset, $onehot0(cmd_i))
   `IPV4C_ASSERT(a_emit_fits, clock, reset, !cmd_i.emit || (status_o.fit_cur && status_o.rsp_free))
   `IPV4C_ASSERT_NEXT(a_cursor_moves, clock, reset, cmd_i.emit && !status_o.is_last, cur_ff > $past(cur_ff))

endmodule

FILE: design/ipv4_range_to_cidr_unit.sv
// Channel   Ports                                   Direction  Handshake
// req       req_start_addr, req_end_addr            in         req_valid / req_ready
// rsp       rsp_block_base, rsp_prefix_len,         out        rsp_valid / rsp_ready
//           rsp_last_block, rsp_range_error
//
// One range is walked at a time; req_ready is high only between ranges.
// A range is a load, B block emits, G <= ADDR_WIDTH block-size grow steps and
// S <= ADDR_WIDTH shrink steps of the size register; a bad range: load, error emit.
// Reset is synchronous and clears the controller state and the result valid.
// A stalled rsp holds the walk at the emit step; the result register keeps the item.
module ipv4_range_to_cidr_unit #(
   parameter int unsigned ADDR_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ipv4c_pkg::FIELD_WIDTH-1:0] req_start_addr,
   input  logic [ipv4c_pkg::FIELD_WIDTH-1:0] req_end_addr,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ipv4c_pkg::FIELD_WIDTH-1:0] rsp_block_base,
   output logic [ipv4c_pkg::PLEN_WIDTH-1:0]  rsp_prefix_len,
   output logic                              rsp_last_block,
   output logic                              rsp_range_error
);

   ipv4c_pkg::cmd_type    cmd;
   ipv4c_pkg::status_type status;

   ipv4c_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   ipv4c_datapath #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_start_addr  (req_start_addr),
      .req_end_addr    (req_end_addr),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_block_base  (rsp_block_base),
      .rsp_prefix_len  (rsp_prefix_len),
      .rsp_last_block  (rsp_last_block),
      .rsp_range_error (rsp_range_error),
      .cmd_i           (cmd),
      .status_o        (status)
   );

endmodule
